### rtl/core/gos_pkg.sv
`default_nettype none

package gos_pkg;

  // Field widths
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned OFF_W     = 24;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 10;

  // Scaling datapath widths
  localparam int unsigned SUMX_W  = OFF_W + 1;
  localparam int unsigned PRODX_W = SUMX_W + SCALE_W + 1;
  localparam int unsigned PRODY_W = RAW_W + SCALE_W + 1;
  localparam int unsigned ACC_W   = FRAC_BITS + COORD_W;

  localparam logic [ACC_W-1:0]   ROUND_BIAS  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_BITS;

  // Output buffer depth
  localparam int unsigned FIFO_DEPTH = 2;

  // Kind of the previously handled point
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2
  } gos_prev_e;

  typedef enum logic {
    SEG_LINE = 1'b0,
    SEG_QUAD = 1'b1
  } gos_seg_e;

  // Raw point as taken from the input stream
  typedef struct packed {
    logic [RAW_W-1:0] px;
    logic [RAW_W-1:0] py;
    logic [OFF_W-1:0] off;
    logic             on;
    logic             last;
  } gos_raw_t;

  // Scaled point
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               last;
  } gos_point_t;

  // Running outline state
  typedef struct packed {
    gos_prev_e          prev;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } gos_trace_t;

  // One output segment
  typedef struct packed {
    logic               last;
    logic               closing;
    gos_seg_e           kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } gos_seg_t;

endpackage

`default_nettype wire

### rtl/core/gos_scaler.sv
`default_nettype none

module gos_scaler import gos_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [SCALE_W-1:0] scale_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire gos_raw_t           in_raw_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      gos_point_t         out_pt_o
);

  logic       raw_v_q;
  gos_raw_t   raw_q;
  logic       pt_v_q;
  gos_point_t pt_q;
  logic       raw_ready;
  logic       pt_ready;

  logic signed [SUMX_W-1:0]  sum_x;
  logic signed [SCALE_W:0]   scale_s;
  logic signed [PRODX_W-1:0] prod_x;
  logic signed [PRODY_W-1:0] prod_y;
  logic        [ACC_W-1:0]   acc_x;
  logic        [ACC_W-1:0]   acc_y;
  gos_point_t                pt_d;

  // Stage handshakes
  assign pt_ready   = !pt_v_q || out_ready_i;
  assign raw_ready  = !raw_v_q || pt_ready;
  assign in_ready_o = raw_ready;

  // Offset x, multiply both by the scale, round and keep the low word
  always_comb begin
    sum_x   = SUMX_W'($signed(raw_q.px)) + SUMX_W'($signed(raw_q.off));
    scale_s = $signed({1'b0, scale_i});
    prod_x  = sum_x * scale_s;
    prod_y  = $signed(raw_q.py) * scale_s;
    acc_x   = ACC_W'(prod_x) + ROUND_BIAS;
    acc_y   = ACC_W'(prod_y) + ROUND_BIAS;
    pt_d.x    = acc_x[ACC_W-1:FRAC_BITS];
    pt_d.y    = acc_y[ACC_W-1:FRAC_BITS];
    pt_d.on   = raw_q.on;
    pt_d.last = raw_q.last;
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_v_q <= 1'b0;
      pt_v_q  <= 1'b0;
    end else begin
      if (raw_ready) raw_v_q <= in_valid_i;
      if (pt_ready)  pt_v_q  <= raw_v_q;
    end
  end

  // Load the payloads
  always_ff @(posedge clk_i) begin
    if (raw_ready && in_valid_i) raw_q <= in_raw_i;
    if (pt_ready && raw_v_q)     pt_q  <= pt_d;
  end

  assign out_valid_o = pt_v_q;
  assign out_pt_o    = pt_q;

endmodule

`default_nettype wire

### rtl/core/gos_segmenter.sv
`default_nettype none

module gos_segmenter import gos_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pt_valid_i,
  output      logic       pt_ready_o,
  input  wire gos_point_t pt_i,
  output      logic       seg_push_o,
  input  wire logic       seg_space_i,
  output      gos_seg_t   seg_o
);

  typedef struct packed {
    logic               emit;
    gos_seg_e           kind;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    gos_trace_t         nxt;
  } gos_step_t;

  // Midpoint truncated toward zero
  function automatic logic [COORD_W-1:0] midpoint(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic [COORD_W:0] sum;
    logic [COORD_W:0] adj;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    adj = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
    return adj[COORD_W:1];
  endfunction

  // Classify one point against the previous kind
  function automatic gos_step_t seg_step(gos_trace_t s, logic [COORD_W-1:0] x,
                                         logic [COORD_W-1:0] y, logic on);
    gos_step_t          r;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    mx = midpoint(x, s.cx);
    my = midpoint(y, s.cy);
    r      = '0;
    r.nxt  = s;
    r.sx   = s.ax;
    r.sy   = s.ay;
    r.kind = SEG_LINE;
    if (s.prev == KIND_ON && on) begin
      r.emit = 1'b1;
      r.ex   = x;
      r.ey   = y;
    end else if (s.prev == KIND_OFF) begin
      r.emit = 1'b1;
      r.kind = SEG_QUAD;
      r.cx   = s.cx;
      r.cy   = s.cy;
      r.ex   = on ? x : mx;
      r.ey   = on ? y : my;
      r.nxt.ax = mx;
      r.nxt.ay = my;
    end
    if (on) begin
      r.nxt.ax   = x;
      r.nxt.ay   = y;
      r.nxt.prev = KIND_ON;
    end else begin
      r.nxt.cx   = x;
      r.nxt.cy   = y;
      r.nxt.prev = KIND_OFF;
    end
    return r;
  endfunction

  function automatic gos_seg_t make_seg(gos_step_t st, logic closing, logic last);
    gos_seg_t g;
    g.last    = last;
    g.closing = closing;
    g.kind    = st.kind;
    g.sx      = st.sx;
    g.sy      = st.sy;
    g.cx      = st.cx;
    g.cy      = st.cy;
    g.ex      = st.ex;
    g.ey      = st.ey;
    return g;
  endfunction

  gos_trace_t         trace_q, trace_d;
  logic [COORD_W-1:0] first_x_q, first_y_q;
  logic               first_on_q;
  logic               at_start_q;
  logic               pend_v_q, pend_v_d;
  gos_seg_t           pend_q;

  gos_step_t          step_pt, step_close;
  logic [COORD_W-1:0] fx, fy;
  logic               fon;
  logic               emit_pt, emit_close;
  gos_seg_t           res0, res1;
  logic               take;

  // Point step, then the closing replay on the updated state
  always_comb begin
    fx  = at_start_q ? pt_i.x  : first_x_q;
    fy  = at_start_q ? pt_i.y  : first_y_q;
    fon = at_start_q ? pt_i.on : first_on_q;
    step_pt    = seg_step(trace_q, pt_i.x, pt_i.y, pt_i.on);
    step_close = seg_step(step_pt.nxt, fx, fy, fon);
    emit_pt    = step_pt.emit;
    emit_close = pt_i.last && step_close.emit;
    res1 = make_seg(step_close, 1'b1, 1'b1);
    res0 = emit_pt ? make_seg(step_pt, 1'b0, !emit_close) : res1;
    trace_d = step_pt.nxt;
    if (pt_i.last) begin
      trace_d      = step_close.nxt;
      trace_d.prev = KIND_NONE;
    end
  end

  // Drain a held second word first, else take the next point
  always_comb begin
    take       = 1'b0;
    seg_push_o = 1'b0;
    seg_o      = res0;
    pend_v_d   = pend_v_q;
    if (pend_v_q) begin
      seg_o      = pend_q;
      seg_push_o = seg_space_i;
      if (seg_space_i) pend_v_d = 1'b0;
    end else if (pt_valid_i) begin
      if (!emit_pt && !emit_close) begin
        take = 1'b1;
      end else if (seg_space_i) begin
        take       = 1'b1;
        seg_push_o = 1'b1;
        pend_v_d   = emit_pt && emit_close;
      end
    end
  end

  assign pt_ready_o = take;

  // Update the outline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_q    <= '0;
      first_x_q  <= '0;
      first_y_q  <= '0;
      first_on_q <= 1'b0;
      at_start_q <= 1'b1;
      pend_v_q   <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      if (take) begin
        trace_q    <= trace_d;
        at_start_q <= pt_i.last;
        if (at_start_q) begin
          first_x_q  <= pt_i.x;
          first_y_q  <= pt_i.y;
          first_on_q <= pt_i.on;
        end
      end
    end
  end

  // Hold the closing word of a two-word point
  always_ff @(posedge clk_i) begin
    if (take) pend_q <= res1;
  end

endmodule

`default_nettype wire

### rtl/core/gos_out_fifo.sv
`default_nettype none

module gos_out_fifo import gos_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire gos_seg_t push_data_i,
  output      logic     space_o,
  output      logic     valid_o,
  input  wire logic     ready_i,
  output      gos_seg_t data_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  gos_seg_t          mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  assign space_o = cnt_q != CntW'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop)    rd_q <= (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

### rtl/core/glyph_outline_segmenter_top.sv
// Path: an accepted point passes the scaler's raw and scaled-point registers, then the output FIFO.
// Throughput: one point per cycle while the output FIFO has space; a point that yields two
//   segment words (a contour end that closes with a segment of its own) holds the segmenter
//   until its second word is pushed, set by the single output word port.
// Reset: rst_ni low clears all valid flags and the outline state at once and
//   loads the scale register with 1.0 (1024).
`default_nettype none

module glyph_outline_segmenter_top import gos_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,     // scale_factor
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,    // point_x, point_y, pen_offset, 8 pad bits
  input  wire logic         s_axis_tuser,    // on_pt
  input  wire logic         s_axis_tlast,    // contour_end
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [191:0] m_axis_tdata,    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
  output      logic [1:0]   m_axis_tuser,    // seg_kind, closing_segment
  output      logic         m_axis_tlast     // last_of_run
);

  logic [SCALE_W-1:0] scale_q;
  gos_raw_t           raw;
  logic               pt_valid, pt_ready;
  gos_point_t         pt;
  logic               seg_push, seg_space;
  gos_seg_t           seg_in, seg_out;

  // Scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // Unpack the input word
  always_comb begin
    raw.px   = s_axis_tdata[15:0];
    raw.py   = s_axis_tdata[31:16];
    raw.off  = s_axis_tdata[55:32];
    raw.on   = s_axis_tuser;
    raw.last = s_axis_tlast;
  end

  gos_scaler u_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_raw_i    (raw),
    .out_valid_o (pt_valid),
    .out_ready_i (pt_ready),
    .out_pt_o    (pt)
  );

  gos_segmenter u_segmenter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_i        (pt),
    .seg_push_o  (seg_push),
    .seg_space_i (seg_space),
    .seg_o       (seg_in)
  );

  gos_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (seg_push),
    .push_data_i (seg_in),
    .space_o     (seg_space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (seg_out)
  );

  // Pack the output word
  assign m_axis_tdata = {seg_out.ey, seg_out.ex, seg_out.cy, seg_out.cx,
                         seg_out.sy, seg_out.sx};
  assign m_axis_tuser = {seg_out.closing, seg_out.kind};
  assign m_axis_tlast = seg_out.last;

endmodule

`default_nettype wire

### rtl/core/gos_checker.sv
`default_nettype none

module gos_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // Stalled word stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  // Stalled word keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // Closing segment always ends the run of its point
  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("closing segment without last flag");

  // Lines carry a zero control point
  a_line_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[127:64] == 64'd0)
    else $error("line segment with nonzero control point");

endmodule

bind glyph_outline_segmenter_top gos_checker u_gos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
